/* sv/mono_upmix_nearest_resampler_unit_macros.svh */
// ---------------------------------------------------------------------------
// mono upmix resampler assertion macros
// concurrent checks clocked on clock and held off while reset is high
// ---------------------------------------------------------------------------
`ifndef MONO_UPMIX_NEAREST_RESAMPLER_UNIT_MACROS_SVH
`define MONO_UPMIX_NEAREST_RESAMPLER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MUPR_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mupr check failed");

`define MUPR_ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("mupr check failed");

`else

`define MUPR_ASSERT_IMPLIES(lbl, ante, cons)

`define MUPR_ASSERT_NEVER(lbl, expr)

`endif

`endif

/* sv/mupr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mupr_pkg
// shared constants, codes and types of the mono upmix resampler
// ---------------------------------------------------------------------------
package mupr_pkg;

   localparam int unsigned MAX_FRAMES  = 1024;
   localparam int unsigned ADDR_W      = $clog2(MAX_FRAMES);
   localparam int unsigned LOAD_W      = $clog2(MAX_FRAMES + 1);
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned FRAME_W     = 2 * SAMPLE_W;
   localparam int unsigned RATE_W      = 17;
   localparam int unsigned COUNT_W     = 13;
   localparam int unsigned PROD_W      = COUNT_W + RATE_W;
   localparam int unsigned DIV_CNT_W   = $clog2(PROD_W);
   localparam int unsigned OUT_RATE    = 44100;
   localparam int unsigned EMIT_MAX    = 8191;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned OP_W        = 2;
   localparam int unsigned CSR_IDX_W   = 1;

   // ceil(2^46 / 44100): exact floor division by 44100 for products below 2^30
   localparam int unsigned RECIP_W     = 31;
   localparam int unsigned RECIP_SHIFT = 46;
   localparam int unsigned SCALE_W     = PROD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_OUT_RATE = 31'd1595663134;

   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_RATE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_MODE = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_CLOSE = 2'd1,
      OP_PULL  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type               kind;
      logic [SAMPLE_W-1:0]  left;
      logic [SAMPLE_W-1:0]  right;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

/* sv/mono_upmix_nearest_resampler_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mono_upmix_nearest_resampler_unit
// buffers pcm frames and replays them as 44100 hz stereo, nearest frame
// ---------------------------------------------------------------------------
// req channel: tuser is the opcode (load, close, pull), tdata the frame.
// loads fill the frame buffer, a close fixes the output frame count, each
// pull returns one result item on the rsp channel (tuser = frame present,
// tlast = last frame of the buffer); loads and closes give no result.
// csr port: index 0 input rate in hz, index 1 stereo mode; write only while
// no item is in flight.
// a two-entry command queue sits between intake and execution, so req keeps
// flowing while a result waits on rsp.
// path of an item in the execution side: a load finishes in idle, a pull
// with no frame pending goes straight to resp, a pull with a frame steps
// through mul, div, read and resp, and a close goes through mul and then
// waits in div for the bit-serial divider; read covers the registered ram.
// a result sits in the rsp register until taken; while rsp stalls, execution
// stops at the next pull and the queue then fills and drops req_tready.
// reset empties the buffer and the queue and restores rate 44100 and stereo
// mode; the frame memory is not cleared, there is no warm-up pass.
// ---------------------------------------------------------------------------
module mono_upmix_nearest_resampler_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mupr_pkg::FRAME_W-1:0]     req_tdata,  // sample_left, sample_right
   input  logic [mupr_pkg::OP_W-1:0]        req_tuser,  // opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mupr_pkg::FRAME_W-1:0]     rsp_tdata,  // out_left, out_right
   output logic                             rsp_tuser,  // out_valid
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [mupr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mupr_pkg::RATE_W-1:0]      csr_wdata
);
   import mupr_pkg::*;

   head_type head;
   logic     pop;

   mupr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   mupr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* sv/mupr_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mupr_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module mupr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mupr_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mupr_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`include "mono_upmix_nearest_resampler_unit_macros.svh"

module mupr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mupr_pkg::PROD_W-1:0]   dividend,
   input  logic [mupr_pkg::RATE_W-1:0]   divisor,
   output logic                          done,
   output logic [mupr_pkg::PROD_W-1:0]   quotient
);
   import mupr_pkg::*;

   logic                  busy_ff,    busy_in;
   logic                  done_ff,    done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff,     cnt_in;
   logic [PROD_W-1:0]     quo_ff,     quo_in;
   logic [RATE_W-1:0]     rem_ff,     rem_in;
   logic [RATE_W-1:0]     dsr_ff,     dsr_in;
   logic [RATE_W:0]       trial;
   logic                  fits;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = RATE_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[RATE_W-1:0];
         end
         quo_in = {quo_ff[PROD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `MUPR_ASSERT_IMPLIES(a_div_start_idle, start, !busy_ff)
   `MUPR_ASSERT_IMPLIES(a_div_done_idle, done_ff, !busy_ff)

endmodule

/* sv/mupr_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mupr_front
// takes request items, drops unknown opcodes, queues commands
// ---------------------------------------------------------------------------
`include "mono_upmix_nearest_resampler_unit_macros.svh"

module mupr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mupr_pkg::FRAME_W-1:0]     req_tdata,
   input  logic [mupr_pkg::OP_W-1:0]        req_tuser,
   output mupr_pkg::head_type               head,
   input  logic                             pop
);
   import mupr_pkg::*;

   cmd_type             mem_ff [QUEUE_DEPTH];
   cmd_type             entry;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                known_op;
   logic                push;

   always_comb begin
      case (op_type'(req_tuser))
         OP_LOAD, OP_CLOSE, OP_PULL: known_op = 1'b1;
         default:                    known_op = 1'b0;
      endcase
   end

   assign req_tready  = count_ff < QCNT_W'(QUEUE_DEPTH);
   // unknown opcodes are taken and thrown away
   assign push        = req_tvalid && req_tready && known_op;
   assign entry.kind  = op_type'(req_tuser);
   assign entry.left  = req_tdata[SAMPLE_W-1:0];
   assign entry.right = req_tdata[FRAME_W-1:SAMPLE_W];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.cmd   = mem_ff[rd_ptr_ff];

   `MUPR_ASSERT_NEVER(a_queue_bound, count_ff > QCNT_W'(QUEUE_DEPTH))
   `MUPR_ASSERT_IMPLIES(a_pop_nonempty, pop, count_ff != '0)

endmodule

/* sv/mupr_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mupr_back
// executes queued commands: frame store, output count, nearest frame pull
// ---------------------------------------------------------------------------
`include "mono_upmix_nearest_resampler_unit_macros.svh"

module mupr_back (
   input  logic                             clock,
   input  logic                             reset,
   input  mupr_pkg::head_type               head,
   output logic                             pop,
   input  logic                             csr_we,
   input  logic [mupr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mupr_pkg::RATE_W-1:0]      csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mupr_pkg::FRAME_W-1:0]     rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import mupr_pkg::*;

   state_type           state_ff,    state_in;
   logic [RATE_W-1:0]   rate_ff;
   logic                stereo_ff;
   logic [LOAD_W-1:0]   loaded_ff,   loaded_in;
   logic [COUNT_W-1:0]  to_emit_ff,  to_emit_in;
   logic [COUNT_W-1:0]  idx_ff,      idx_in;
   logic                closed_ff,   closed_in;
   logic                is_close_ff, is_close_in;
   logic                zero_ff,     zero_in;
   logic [PROD_W-1:0]   prod_ff,     prod_in;
   logic [PROD_W-1:0]   scaled_ff,   scaled_in;
   logic [RATE_W-1:0]   divisor_ff,  divisor_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]  rsp_data_ff,  rsp_data_in;
   logic                rsp_user_ff,  rsp_user_in;
   logic                rsp_last_ff,  rsp_last_in;

   logic [RATE_W-1:0]   eff_rate;
   logic [COUNT_W-1:0]  mul_a;
   logic [RATE_W-1:0]   mul_b;
   logic [SCALE_W-1:0]  scale_prod;
   logic                pending;
   logic                out_free;
   logic                is_last;
   logic                div_start;
   logic                div_done;
   logic [PROD_W-1:0]   quotient;
   logic                ram_we;
   logic [FRAME_W-1:0]  ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [FRAME_W-1:0]  ram_rdata;
   logic [LOAD_W-1:0]   last_frame;

   // a rate of zero counts as the output rate
   assign eff_rate   = (rate_ff == '0) ? RATE_W'(OUT_RATE) : rate_ff;
   assign pending    = closed_ff && (idx_ff < to_emit_ff) && (loaded_ff != '0);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_last    = ({1'b0, idx_ff} + 1'b1) >= {1'b0, to_emit_ff};
   assign last_frame = loaded_ff - 1'b1;
   assign mul_a      = (head.cmd.kind == OP_CLOSE) ? COUNT_W'(loaded_ff) : idx_ff;
   assign mul_b      = (head.cmd.kind == OP_CLOSE) ? RATE_W'(OUT_RATE) : eff_rate;
   assign ram_wdata  = {stereo_ff ? head.cmd.right : head.cmd.left, head.cmd.left};
   // source frame of a pull: divide by the output rate through its reciprocal
   assign scale_prod = SCALE_W'(prod_ff) * SCALE_W'(RECIP_OUT_RATE);

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      to_emit_in   = to_emit_ff;
      idx_in       = idx_ff;
      closed_in    = closed_ff;
      is_close_in  = is_close_ff;
      zero_in      = zero_ff;
      prod_in      = prod_ff;
      scaled_in    = scaled_ff;
      divisor_in   = divisor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
               case (head.cmd.kind)
                  OP_LOAD: begin
                     if (!closed_ff && (loaded_ff < LOAD_W'(MAX_FRAMES))) begin
                        ram_we    = 1'b1;
                        loaded_in = loaded_ff + 1'b1;
                     end
                  end
                  OP_CLOSE: begin
                     if (!closed_ff && (loaded_ff != '0)) begin
                        is_close_in = 1'b1;
                        divisor_in  = eff_rate;
                        state_in    = ST_MUL;
                     end
                  end
                  OP_PULL: begin
                     is_close_in = 1'b0;
                     zero_in     = !pending;
                     state_in    = pending ? ST_MUL : ST_RESP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (is_close_ff) begin
               div_start = 1'b1;
            end else begin
               scaled_in = PROD_W'(scale_prod[SCALE_W-1:RECIP_SHIFT]);
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (is_close_ff) begin
               if (div_done) begin
                  if (quotient == '0) begin
                     to_emit_in = COUNT_W'(1);
                  end else if (quotient > PROD_W'(EMIT_MAX)) begin
                     to_emit_in = COUNT_W'(EMIT_MAX);
                  end else begin
                     to_emit_in = quotient[COUNT_W-1:0];
                  end
                  idx_in    = '0;
                  closed_in = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               // source index past the end reads the last stored frame
               ram_re = 1'b1;
               if (scaled_ff >= PROD_W'(loaded_ff)) begin
                  ram_raddr = last_frame[ADDR_W-1:0];
               end else begin
                  ram_raddr = scaled_ff[ADDR_W-1:0];
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  rsp_data_in = '0;
                  rsp_user_in = 1'b0;
                  rsp_last_in = 1'b0;
               end else begin
                  rsp_data_in = ram_rdata;
                  rsp_user_in = 1'b1;
                  rsp_last_in = is_last;
                  if (is_last) begin
                     loaded_in  = '0;
                     to_emit_in = '0;
                     idx_in     = '0;
                     closed_in  = 1'b0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_W'(OUT_RATE);
         stereo_ff    <= 1'b1;
         loaded_ff    <= '0;
         to_emit_ff   <= '0;
         idx_ff       <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         to_emit_ff   <= to_emit_in;
         idx_ff       <= idx_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_INPUT_RATE:  rate_ff   <= csr_wdata;
               CSR_STEREO_MODE: stereo_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      is_close_ff <= is_close_in;
      zero_ff     <= zero_in;
      prod_ff     <= prod_in;
      scaled_ff   <= scaled_in;
      divisor_ff  <= divisor_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   mupr_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (MAX_FRAMES)
   ) u_frames (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (loaded_ff[ADDR_W-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mupr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `MUPR_ASSERT_NEVER(a_loaded_bound, loaded_ff > LOAD_W'(MAX_FRAMES))
   `MUPR_ASSERT_IMPLIES(a_closed_pending, closed_ff, (to_emit_ff != '0) && (idx_ff < to_emit_ff))
   `MUPR_ASSERT_IMPLIES(a_empty_rsp, rsp_valid_ff && !rsp_user_ff, (rsp_data_ff == '0) && !rsp_last_ff)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the nearest-frame 44100 hz stereo resampler
// ---------------------------------------------------------------------------
// an initial block queues load, close and pull items in phases and writes
// the rate and stereo registers while the unit is idle. a clocked driver
// offers the queued items on req with random gaps. a clocked monitor takes
// rsp items with random stalls and one long hold-off, and compares each one
// with the frame that the in-bench buffer model predicted for its pull.
// ---------------------------------------------------------------------------
module tb_top;
   import mupr_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_PCT     = 21;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 120;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_ITEMS  = 850;

   typedef struct {
      logic [OP_W-1:0]     opcode;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
   } pcm_item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                present;
      logic                last;
   } frame_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [FRAME_W-1:0]    req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = OP_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [FRAME_W-1:0]    rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [RATE_W-1:0]     csr_wdata = '0;

   pcm_item_type  pending_items[$];
   frame_out_type expected_frames[$];
   pcm_item_type  offered;
   frame_out_type seen_frame;
   frame_out_type due_frame;
   int         mismatch_count = 0;
   int         work_items = 0;
   bit         calm = 1'b0;
   bit         hold_arm = 1'b0;
   bit         hold_used;
   int         hold_cycles;

   // buffer model
   logic [SAMPLE_W-1:0] left_mem [MAX_FRAMES];
   logic [SAMPLE_W-1:0] right_mem [MAX_FRAMES];
   logic [RATE_W-1:0]   rate_reg = RATE_W'(OUT_RATE);
   bit                  stereo_reg = 1'b1;
   int unsigned         loaded = 0;
   int unsigned         emit_total = 0;
   int unsigned         emit_pos = 0;
   bit                  closed = 1'b0;

   mono_upmix_nearest_resampler_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned active_rate();
      return (rate_reg == '0) ? longint'(OUT_RATE) : longint'(rate_reg);
   endfunction

   function automatic int unsigned emit_count(input int unsigned frames);
      longint unsigned cnt;
      cnt = (64'(frames) * OUT_RATE) / active_rate();
      if (cnt < 1) cnt = 1;
      if (cnt > EMIT_MAX) cnt = EMIT_MAX;
      return int'(cnt);
   endfunction

   task automatic resample_step(input pcm_item_type it);
      frame_out_type   r;
      longint unsigned src;
      r = '0;
      case (it.opcode)
         OP_LOAD: begin
            if (!closed && loaded < MAX_FRAMES) begin
               left_mem[loaded]  = it.left;
               right_mem[loaded] = stereo_reg ? it.right : it.left;
               loaded++;
            end
         end
         OP_CLOSE: begin
            if (!closed && loaded > 0) begin
               emit_total = emit_count(loaded);
               emit_pos   = 0;
               closed     = 1'b1;
            end
         end
         OP_PULL: begin
            if (closed && emit_pos < emit_total && loaded != 0) begin
               // rate is read at each pull, so a rewrite after close counts
               src = (64'(emit_pos) * active_rate()) / OUT_RATE;
               if (src >= loaded) src = loaded - 1;
               if (src >= MAX_FRAMES) src = MAX_FRAMES - 1;
               r.left    = left_mem[src];
               r.right   = right_mem[src];
               r.present = 1'b1;
               r.last    = (emit_pos + 1 >= emit_total);
               if (r.last) begin
                  loaded     = 0;
                  emit_total = 0;
                  emit_pos   = 0;
                  closed     = 1'b0;
               end else begin
                  emit_pos++;
               end
            end
            expected_frames.push_back(r);
         end
         default: ;
      endcase
   endtask

   function automatic bit stall_roll();
      return !calm && ($urandom_range(99) < STALL_PCT);
   endfunction

   task automatic flag_mismatch(input string what, input frame_out_type want,
                                input frame_out_type got);
      if (mismatch_count < REPORT_LIMIT)
         $display("%0t %s: expected L=%h R=%h valid=%b last=%b, got L=%h R=%h valid=%b last=%b",
                  $realtime, what, want.left, want.right, want.present, want.last,
                  got.left, got.right, got.present, got.last);
      mismatch_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) resample_step(offered);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && !stall_roll()) begin
               offered = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {offered.right, offered.left};
               req_tuser  <= offered.opcode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the command queue backs up into req
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_used   <= 1'b0;
      end else if (hold_arm && !hold_used) begin
         hold_cycles <= HOLD_CYCLES;
         hold_used   <= 1'b1;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_frame = '{left: rsp_tdata[SAMPLE_W-1:0],
                           right: rsp_tdata[FRAME_W-1:SAMPLE_W],
                           present: rsp_tuser, last: rsp_tlast};
            if (expected_frames.size() == 0) begin
               flag_mismatch("unexpected item", '0, seen_frame);
            end else begin
               due_frame = expected_frames.pop_front();
               if (seen_frame.left !== due_frame.left || seen_frame.right !== due_frame.right ||
                   seen_frame.present !== due_frame.present ||
                   seen_frame.last !== due_frame.last)
                  flag_mismatch("frame mismatch", due_frame, seen_frame);
            end
         end
         rsp_tready <= (hold_cycles == 0) && !stall_roll();
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_frames.size() != 0);
      // a close gives no item, so let the divider and the queue run dry
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_INPUT_RATE) rate_reg = val;
      else stereo_reg = val[0];
   endtask

   task automatic push_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] l,
                            input logic [SAMPLE_W-1:0] r);
      pending_items.push_back('{opcode: op, left: l, right: r});
   endtask

   task automatic push_pulls(input int k);
      repeat (k) push_item(OP_PULL, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      work_items += k;
   endtask

   task automatic fill_buffer(input int n, input int pulls);
      for (int i = 0; i < n; i++) begin
         // a little noise ahead of the close: unused opcode or an early pull
         if ($urandom_range(99) < 4)
            push_item($urandom_range(1) ? OP_UNUSED : OP_PULL,
                      SAMPLE_W'($urandom), SAMPLE_W'($urandom));
         push_item(OP_LOAD, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      end
      push_item(OP_CLOSE, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      if ($urandom_range(9) == 0) push_item(OP_CLOSE, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      if ($urandom_range(9) == 0) push_item(OP_LOAD, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      work_items += n + 1;
      push_pulls(pulls);
   endtask

   initial begin
      int                n;
      int                cnt;
      int                pulls;
      int                phase;
      logic [RATE_W-1:0] rate_pick;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty buffer: pull with nothing pending, close of an empty buffer
      push_item(OP_PULL, 16'hFFFF, 16'hFFFF);
      push_item(OP_CLOSE, 16'h0000, 16'h0000);
      push_item(OP_PULL, 16'h0000, 16'h0000);
      push_item(OP_LOAD, 16'h8000, 16'h7FFF);
      push_item(OP_LOAD, 16'h7FFF, 16'h8000);
      push_item(OP_LOAD, 16'h0000, 16'hFFFF);
      push_item(OP_UNUSED, 16'hA5A5, 16'h5A5A);
      push_item(OP_CLOSE, 16'h0000, 16'h0000);
      // second close and a load while closed are both dropped
      push_item(OP_CLOSE, 16'h0000, 16'h0000);
      push_item(OP_LOAD, 16'h1234, 16'h4321);
      repeat (4) push_item(OP_PULL, 16'h0000, 16'h0000);
      wait_idle();

      // rate zero falls back to 44100, mono copies left into right
      write_reg(CSR_INPUT_RATE, '0);
      write_reg(CSR_STEREO_MODE, RATE_W'(0));
      push_item(OP_LOAD, 16'hFFFF, 16'h1234);
      push_item(OP_LOAD, 16'h0001, 16'h8000);
      push_item(OP_CLOSE, 16'h0000, 16'h0000);
      repeat (3) push_item(OP_PULL, 16'h0000, 16'h0000);
      wait_idle();

      // rate rewritten mid-drain, source index runs past the end and clamps
      write_reg(CSR_INPUT_RATE, RATE_W'(8000));
      write_reg(CSR_STEREO_MODE, RATE_W'(1));
      fill_buffer(3, 4);
      wait_idle();
      write_reg(CSR_INPUT_RATE, RATE_W'(96000));
      push_pulls(emit_total - emit_pos + 1);
      wait_idle();

      // full buffer with overflow loads at the highest rate, under back-pressure
      write_reg(CSR_INPUT_RATE, '1);
      fill_buffer(MAX_FRAMES + 2, 0);
      wait_idle();
      hold_arm = 1'b1;
      push_pulls(emit_total + 1);

      work_items = 0;
      phase = 0;
      while (work_items < RANDOM_ITEMS) begin
         wait_idle();
         calm = (phase >= 6 && phase < 10);
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(9))
               0:       rate_pick = '0;
               1:       rate_pick = '1;
               2:       rate_pick = RATE_W'($urandom_range(131071, 4000));
               default: rate_pick = RATE_W'($urandom_range(96000, 8000));
            endcase
            write_reg(CSR_INPUT_RATE, rate_pick);
         end
         if ($urandom_range(2) == 0) write_reg(CSR_STEREO_MODE, RATE_W'($urandom_range(1)));
         if (closed) begin
            // finish a buffer left half drained by the previous phase
            push_pulls(emit_total - emit_pos + $urandom_range(1));
         end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(80, 25) : $urandom_range(24, 1);
            cnt = emit_count(n);
            pulls = ($urandom_range(4) == 0) ? $urandom_range(cnt, 1) : cnt + $urandom_range(1);
            fill_buffer(n, pulls);
         end
         phase++;
      end
      wait_idle();
      calm = 1'b0;

      // tiny rate: the output count saturates at its 13-bit limit
      write_reg(CSR_INPUT_RATE, RATE_W'(1));
      write_reg(CSR_STEREO_MODE, RATE_W'($urandom_range(1)));
      fill_buffer(2, EMIT_MAX + 1);
      wait_idle();

      if (mismatch_count == 0 && expected_frames.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
